// File: src/tcle_pkg.sv
// ----------------------------------------------------------------------------
// tcle_pkg
// Shared constants, codes and command/status types of the cooked line editor.
// ----------------------------------------------------------------------------
package tcle_pkg;

  localparam int LINE_SIZE = 32;
  localparam int IDX_W     = $clog2(LINE_SIZE);
  localparam int CUR_W     = $clog2(LINE_SIZE + 1);
  localparam int MAX_RES   = 64;
  localparam int RES_W     = $clog2(MAX_RES);
  localparam int RCNT_W    = $clog2(MAX_RES + 1);

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAW_MODE    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ECHO_ENABLE = 1'd1;

  // result kinds
  localparam logic [2:0] K_ECHO    = 3'd0;
  localparam logic [2:0] K_ERASE   = 3'd1;
  localparam logic [2:0] K_BACK    = 3'd2;
  localparam logic [2:0] K_NEWLINE = 3'd3;
  localparam logic [2:0] K_BANNER  = 3'd4;
  localparam logic [2:0] K_LINE    = 3'd5;
  localparam logic [2:0] K_STATUS  = 3'd6;

  // character codes
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_SUB    = 8'd26;
  localparam logic [6:0] C_CR      = 7'd13;
  localparam logic [6:0] C_LF      = 7'd10;
  localparam logic [6:0] C_KILL_A  = 7'd21;
  localparam logic [6:0] C_KILL_B  = 7'd25;
  localparam logic [6:0] C_RECALL  = 7'd5;
  localparam logic [6:0] C_FWD     = 7'd4;
  localparam logic [6:0] C_FWDWORD = 7'd6;
  localparam logic [6:0] C_BACK    = 7'd19;
  localparam logic [6:0] C_DEL     = 7'h7f;
  localparam logic [6:0] C_BS      = 7'd8;
  localparam logic [6:0] C_RETYPE  = 7'd18;
  localparam logic [6:0] C_LNEXT   = 7'd22;
  localparam logic [6:0] C_WERASE  = 7'd23;
  localparam logic [6:0] C_WBACK   = 7'd1;

  // character classes
  typedef logic [3:0] cls_t;
  localparam cls_t CL_OTHER  = 4'd0;
  localparam cls_t CL_EOL    = 4'd1;
  localparam cls_t CL_KILL   = 4'd2;
  localparam cls_t CL_RECALL = 4'd3;
  localparam cls_t CL_FWD    = 4'd4;
  localparam cls_t CL_FWDW   = 4'd5;
  localparam cls_t CL_BACK   = 4'd6;
  localparam cls_t CL_RUB    = 4'd7;
  localparam cls_t CL_RETYPE = 4'd8;
  localparam cls_t CL_LNEXT  = 4'd9;
  localparam cls_t CL_WERASE = 4'd10;
  localparam cls_t CL_WBACK  = 4'd11;

  // datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_ACCEPT    = 5'd1;
  localparam op_t OP_PUT       = 5'd2;
  localparam op_t OP_TRUNC     = 5'd3;
  localparam op_t OP_EOL       = 5'd4;
  localparam op_t OP_RAW       = 5'd5;
  localparam op_t OP_DLV       = 5'd6;
  localparam op_t OP_DLV_END   = 5'd7;
  localparam op_t OP_CUR_CLR   = 5'd8;
  localparam op_t OP_ERASE1    = 5'd9;
  localparam op_t OP_REC_START = 5'd10;
  localparam op_t OP_REC       = 5'd11;
  localparam op_t OP_REC_END   = 5'd12;
  localparam op_t OP_FWD       = 5'd13;
  localparam op_t OP_BACK      = 5'd14;
  localparam op_t OP_WSTEP     = 5'd15;
  localparam op_t OP_BANNER    = 5'd16;
  localparam op_t OP_RETYPE    = 5'd17;
  localparam op_t OP_LNEXT     = 5'd18;
  localparam op_t OP_STATUS    = 5'd19;
  localparam op_t OP_RD        = 5'd20;
  localparam op_t OP_NEXT      = 5'd21;

  // line read address select
  typedef logic [1:0] rsel_t;
  localparam rsel_t RS_CUR   = 2'd0;
  localparam rsel_t RS_CURM1 = 2'd1;
  localparam rsel_t RS_IDX   = 2'd2;

  typedef struct packed {
    op_t   op;
    logic  show;
    logic  werase;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic raw;
    logic echo;
    logic literal;
    logic recall;
    logic cur_zero;
    logic cur_lt_end;
    logic cur_over;
    logic space_rd;
    logic rec_end;
    logic dlv_done;
    logic rt_done;
    logic res_zero;
    logic res_last;
    logic is_sub;
  } sts_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// File: src/tty_cooked_line_editor.sv
// ----------------------------------------------------------------------------
// tty_cooked_line_editor
// Terminal line discipline in cooked mode: edits a line from keyboard bytes
// and emits echo operations and finished line bytes.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[7:0] char_in
//  m_axis    out        tdata[7:0] out_byte, [8] buffer_empty; tuser out_kind;
//                       tlast last
//  cfg       in         cfg_addr 0 raw_mode, 1 echo_enable; cfg_wdata bit 0
//
//  One byte is processed at a time: it is accepted and decoded, each result is
//  built by one datapath operation (word forward/back add a check step per
//  character), then each result is read from the result buffer and offered
//  on m_axis, plus output stalls.
//  Reset clears cursor, edit mark, indexes and flags and sets echo on; no clearing pass.
//  s_axis_tready is low from acceptance until the last result is taken.
// ----------------------------------------------------------------------------
module tty_cooked_line_editor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] char_in
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [7:0] out_byte, [8] buffer_empty
  output logic [2:0]                       m_axis_tuser,   // [2:0] out_kind
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [tcle_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic                             cfg_wdata
);

  tcle_pkg::cmd_t cmd;
  tcle_pkg::sts_t sts;
  logic [7:0]     out_byte;
  logic           buffer_empty;

  tcle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcle_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .char_in      (s_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_kind     (m_axis_tuser),
    .out_byte     (out_byte),
    .buffer_empty (buffer_empty),
    .last         (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, buffer_empty, out_byte};

endmodule

// File: src/tcle_dp.sv
// ----------------------------------------------------------------------------
// tcle_dp
// Datapath: line and previous-line stores, cursor, edit mark, flags, result
// buffer and output register. Executes one operation per cycle.
// ----------------------------------------------------------------------------
module tcle_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  tcle_pkg::cmd_t                   cmd,
  output tcle_pkg::sts_t                   sts,
  input  logic [7:0]                       char_in,
  input  logic                             cfg_we,
  input  logic [tcle_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic                             cfg_wdata,
  output logic [2:0]                       out_kind,
  output logic [7:0]                       out_byte,
  output logic                             buffer_empty,
  output logic                             last
);

  localparam int LS  = tcle_pkg::LINE_SIZE;
  localparam int IW  = tcle_pkg::IDX_W;
  localparam int CW  = tcle_pkg::CUR_W;
  localparam int RW  = tcle_pkg::RES_W;
  localparam int RCW = tcle_pkg::RCNT_W;

  logic [7:0]    line_store [LS];
  logic [7:0]    prev_line  [LS];
  logic [10:0]   res_mem    [tcle_pkg::MAX_RES];

  logic [7:0]    ch;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] edit_end, edit_end_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] dcount, dcount_next;
  logic          eol, eol_next;
  logic          recall, recall_next;
  logic          literal, literal_next;
  logic          raw_mode, echo_en;
  logic [RCW-1:0] rcount;
  logic [RW-1:0] ridx;
  logic [10:0]   rdata;

  logic [CW-1:0] cur_p1, cur_m1;
  logic [CW-1:0] raddr;
  logic [7:0]    line_rd, prev_rd;
  logic          emit;
  logic [2:0]    emit_kind;
  logic [7:0]    emit_byte;
  tcle_pkg::cls_t cls;

  assign cur_p1 = cursor + CW'(1);
  assign cur_m1 = cursor - CW'(1);

  always_comb begin
    case (cmd.rsel)
      tcle_pkg::RS_CUR:   raddr = cursor;
      tcle_pkg::RS_CURM1: raddr = cur_m1;
      tcle_pkg::RS_IDX:   raddr = idx;
      default:            raddr = cursor;
    endcase
  end

  assign line_rd = line_store[raddr[IW-1:0]];
  assign prev_rd = prev_line[idx[IW-1:0]];

  // character class on the low 7 bits
  always_comb begin
    case (ch[6:0])
      tcle_pkg::C_CR, tcle_pkg::C_LF:         cls = tcle_pkg::CL_EOL;
      tcle_pkg::C_KILL_A, tcle_pkg::C_KILL_B: cls = tcle_pkg::CL_KILL;
      tcle_pkg::C_RECALL:                     cls = tcle_pkg::CL_RECALL;
      tcle_pkg::C_FWD:                        cls = tcle_pkg::CL_FWD;
      tcle_pkg::C_FWDWORD:                    cls = tcle_pkg::CL_FWDW;
      tcle_pkg::C_BACK:                       cls = tcle_pkg::CL_BACK;
      tcle_pkg::C_DEL, tcle_pkg::C_BS:        cls = tcle_pkg::CL_RUB;
      tcle_pkg::C_RETYPE:                     cls = tcle_pkg::CL_RETYPE;
      tcle_pkg::C_LNEXT:                      cls = tcle_pkg::CL_LNEXT;
      tcle_pkg::C_WERASE:                     cls = tcle_pkg::CL_WERASE;
      tcle_pkg::C_WBACK:                      cls = tcle_pkg::CL_WBACK;
      default:                                cls = tcle_pkg::CL_OTHER;
    endcase
  end

  assign sts.cls        = cls;
  assign sts.raw        = raw_mode;
  assign sts.echo       = echo_en;
  assign sts.literal    = literal;
  assign sts.recall     = recall;
  assign sts.cur_zero   = (cursor == '0);
  assign sts.cur_lt_end = (cursor < edit_end);
  assign sts.cur_over   = (cursor > CW'(LS - 3));
  assign sts.space_rd   = tcle_pkg::is_space(line_rd);
  assign sts.rec_end    = (idx == CW'(LS - 3)) || (prev_rd == tcle_pkg::CH_CR);
  assign sts.dlv_done   = (idx == dcount);
  assign sts.rt_done    = (idx >= cursor);
  assign sts.res_zero   = (rcount == '0);
  assign sts.res_last   = ({1'b0, ridx} == rcount - RCW'(1));
  assign sts.is_sub     = (ch == tcle_pkg::CH_SUB);

  // result generation and scalar state updates
  always_comb begin
    emit          = 1'b0;
    emit_kind     = tcle_pkg::K_STATUS;
    emit_byte     = '0;
    cursor_next   = cursor;
    edit_end_next = edit_end;
    idx_next      = idx;
    dcount_next   = dcount;
    eol_next      = eol;
    recall_next   = recall;
    literal_next  = literal;
    case (cmd.op)
      tcle_pkg::OP_PUT: begin
        cursor_next  = cur_p1;
        literal_next = 1'b0;
        emit         = cmd.show;
        emit_kind    = tcle_pkg::K_ECHO;
        emit_byte    = ch;
      end
      tcle_pkg::OP_TRUNC: begin
        idx_next    = '0;
        dcount_next = CW'(LS);
        eol_next    = 1'b0;
      end
      tcle_pkg::OP_EOL: begin
        emit        = 1'b1;
        emit_kind   = tcle_pkg::K_NEWLINE;
        idx_next    = '0;
        dcount_next = cursor + CW'(2);
        eol_next    = 1'b1;
      end
      tcle_pkg::OP_RAW: begin
        idx_next    = '0;
        dcount_next = cur_p1;
        eol_next    = 1'b0;
      end
      tcle_pkg::OP_DLV: begin
        emit      = 1'b1;
        emit_kind = tcle_pkg::K_LINE;
        emit_byte = line_rd;
        idx_next  = idx + CW'(1);
      end
      tcle_pkg::OP_DLV_END: begin
        cursor_next = '0;
        if (eol) begin
          edit_end_next = '0;
          recall_next   = 1'b0;
        end
      end
      tcle_pkg::OP_CUR_CLR: cursor_next = '0;
      tcle_pkg::OP_ERASE1: begin
        cursor_next = cur_m1;
        emit        = 1'b1;
        emit_kind   = tcle_pkg::K_ERASE;
      end
      tcle_pkg::OP_REC_START: idx_next = '0;
      tcle_pkg::OP_REC: begin
        emit      = 1'b1;
        emit_kind = tcle_pkg::K_ECHO;
        emit_byte = prev_rd;
        idx_next  = idx + CW'(1);
      end
      tcle_pkg::OP_REC_END: begin
        cursor_next = idx;
        if (idx != '0) begin
          edit_end_next = idx;
          recall_next   = 1'b1;
        end
      end
      tcle_pkg::OP_FWD: begin
        emit        = 1'b1;
        emit_kind   = tcle_pkg::K_ECHO;
        emit_byte   = line_rd;
        cursor_next = cur_p1;
      end
      tcle_pkg::OP_BACK: begin
        emit        = 1'b1;
        emit_kind   = tcle_pkg::K_BACK;
        cursor_next = cur_m1;
      end
      tcle_pkg::OP_WSTEP: begin
        emit        = 1'b1;
        emit_kind   = cmd.werase ? tcle_pkg::K_ERASE : tcle_pkg::K_BACK;
        cursor_next = cur_m1;
      end
      tcle_pkg::OP_BANNER: begin
        emit      = 1'b1;
        emit_kind = tcle_pkg::K_BANNER;
        idx_next  = '0;
      end
      tcle_pkg::OP_RETYPE: begin
        emit      = 1'b1;
        emit_kind = tcle_pkg::K_ECHO;
        emit_byte = line_rd;
        idx_next  = idx + CW'(1);
      end
      tcle_pkg::OP_LNEXT:  literal_next = 1'b1;
      tcle_pkg::OP_STATUS: emit = 1'b1;
      default: ;
    endcase
    // a raw mode write drops a pending literal
    if (cfg_we && (cfg_addr == tcle_pkg::CFG_RAW_MODE)) begin
      literal_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      edit_end <= '0;
      idx      <= '0;
      dcount   <= '0;
      eol      <= 1'b0;
      recall   <= 1'b0;
      literal  <= 1'b0;
      raw_mode <= 1'b0;
      echo_en  <= 1'b1;
      rcount   <= '0;
      ridx     <= '0;
    end else begin
      cursor   <= cursor_next;
      edit_end <= edit_end_next;
      idx      <= idx_next;
      dcount   <= dcount_next;
      eol      <= eol_next;
      recall   <= recall_next;
      literal  <= literal_next;
      if (cfg_we) begin
        if (cfg_addr == tcle_pkg::CFG_RAW_MODE) begin
          raw_mode <= cfg_wdata;
        end else if (cfg_addr == tcle_pkg::CFG_ECHO_ENABLE) begin
          echo_en <= cfg_wdata;
        end
      end
      if (cmd.op == tcle_pkg::OP_ACCEPT) begin
        rcount <= '0;
        ridx   <= '0;
      end else begin
        if (emit && (rcount < RCW'(tcle_pkg::MAX_RES))) begin
          rcount <= rcount + RCW'(1);
        end
        if (cmd.op == tcle_pkg::OP_NEXT) begin
          ridx <= ridx + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tcle_pkg::OP_ACCEPT) begin
      ch <= char_in;
    end
  end

  // line store: up to two entries written per operation
  always_ff @(posedge clk) begin
    case (cmd.op)
      tcle_pkg::OP_PUT, tcle_pkg::OP_RAW: line_store[cursor[IW-1:0]] <= ch;
      tcle_pkg::OP_EOL: begin
        line_store[cursor[IW-1:0]] <= tcle_pkg::CH_CR;
        line_store[cur_p1[IW-1:0]] <= tcle_pkg::CH_LF;
      end
      tcle_pkg::OP_TRUNC: begin
        line_store[IW'(LS - 2)] <= tcle_pkg::CH_CR;
        line_store[IW'(LS - 1)] <= tcle_pkg::CH_LF;
      end
      tcle_pkg::OP_REC: line_store[idx[IW-1:0]] <= prev_rd;
      default: ;
    endcase
  end

  // previous line: copied during delivery of a finished line
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_line[0] <= tcle_pkg::CH_CR;
    end else if ((cmd.op == tcle_pkg::OP_DLV) && eol) begin
      if (idx < cursor) begin
        prev_line[idx[IW-1:0]] <= line_rd;
      end else if (idx == cursor) begin
        prev_line[idx[IW-1:0]] <= tcle_pkg::CH_CR;
      end
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (emit && (rcount < RCW'(tcle_pkg::MAX_RES))) begin
      res_mem[rcount[RW-1:0]] <= {emit_kind, emit_byte};
    end
    if (cmd.op == tcle_pkg::OP_RD) begin
      rdata <= res_mem[ridx];
    end
  end

  assign out_kind     = rdata[10:8];
  assign out_byte     = rdata[7:0];
  assign buffer_empty = (cursor == '0);
  assign last         = sts.res_last;

endmodule

// File: src/tcle_ctrl.sv
// ----------------------------------------------------------------------------
// tcle_ctrl
// Controller: decodes each accepted byte and sequences the datapath through
// the edit, delivers the buffered results, then returns to idle.
// ----------------------------------------------------------------------------
module tcle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tcle_pkg::sts_t  sts,
  output tcle_pkg::cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_PCHK   = 4'd2;
  localparam logic [3:0] ST_DLV    = 4'd3;
  localparam logic [3:0] ST_ERASE  = 4'd4;
  localparam logic [3:0] ST_REC    = 4'd5;
  localparam logic [3:0] ST_FWD    = 4'd6;
  localparam logic [3:0] ST_FWDCHK = 4'd7;
  localparam logic [3:0] ST_RETYPE = 4'd8;
  localparam logic [3:0] ST_WORD0  = 4'd9;
  localparam logic [3:0] ST_WORD   = 4'd10;
  localparam logic [3:0] ST_WCHK   = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;
  localparam logic [3:0] ST_RD     = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  logic [3:0] state, state_next;
  logic       to_rec, to_rec_next;
  logic       werase, werase_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next  = state;
    to_rec_next = to_rec;
    werase_next = werase;
    cmd.op      = tcle_pkg::OP_NONE;
    cmd.show    = 1'b0;
    cmd.werase  = werase;
    cmd.rsel    = tcle_pkg::RS_CUR;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = tcle_pkg::OP_ACCEPT;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        state_next = ST_FIN;
        if (sts.literal) begin
          cmd.op     = tcle_pkg::OP_PUT;
          cmd.show   = 1'b1;
          state_next = ST_PCHK;
        end else if (sts.raw) begin
          cmd.op     = tcle_pkg::OP_RAW;
          state_next = ST_DLV;
        end else begin
          case (sts.cls)
            tcle_pkg::CL_EOL: begin
              cmd.op     = tcle_pkg::OP_EOL;
              state_next = ST_DLV;
            end
            tcle_pkg::CL_KILL: begin
              if (sts.echo) begin
                to_rec_next = 1'b0;
                state_next  = ST_ERASE;
              end else begin
                cmd.op = tcle_pkg::OP_CUR_CLR;
              end
            end
            tcle_pkg::CL_RECALL: begin
              if (!sts.recall) begin
                if (sts.echo) begin
                  to_rec_next = 1'b1;
                  state_next  = ST_ERASE;
                end else begin
                  cmd.op = tcle_pkg::OP_CUR_CLR;
                end
              end
            end
            tcle_pkg::CL_FWD: begin
              if (sts.recall && sts.cur_lt_end) begin
                cmd.op = tcle_pkg::OP_FWD;
              end
            end
            tcle_pkg::CL_FWDW: begin
              if (sts.recall) state_next = ST_FWD;
            end
            tcle_pkg::CL_BACK: begin
              if (sts.recall && !sts.cur_zero) cmd.op = tcle_pkg::OP_BACK;
            end
            tcle_pkg::CL_RUB: begin
              if (!sts.cur_zero) cmd.op = tcle_pkg::OP_ERASE1;
            end
            tcle_pkg::CL_RETYPE: begin
              if (sts.echo) begin
                cmd.op     = tcle_pkg::OP_BANNER;
                state_next = ST_RETYPE;
              end
            end
            tcle_pkg::CL_LNEXT: cmd.op = tcle_pkg::OP_LNEXT;
            tcle_pkg::CL_WERASE, tcle_pkg::CL_WBACK: begin
              if (sts.echo) begin
                werase_next = (sts.cls == tcle_pkg::CL_WERASE);
                state_next  = ST_WORD0;
              end
            end
            default: begin
              cmd.op     = tcle_pkg::OP_PUT;
              cmd.show   = sts.echo && !sts.is_sub;
              state_next = ST_PCHK;
            end
          endcase
        end
      end
      ST_PCHK: begin
        if (sts.cur_over) begin
          cmd.op     = tcle_pkg::OP_TRUNC;
          state_next = ST_DLV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DLV: begin
        cmd.rsel = tcle_pkg::RS_IDX;
        if (sts.dlv_done) begin
          cmd.op     = tcle_pkg::OP_DLV_END;
          state_next = ST_FIN;
        end else begin
          cmd.op = tcle_pkg::OP_DLV;
        end
      end
      ST_ERASE: begin
        if (!sts.cur_zero) begin
          cmd.op = tcle_pkg::OP_ERASE1;
        end else if (to_rec) begin
          cmd.op     = tcle_pkg::OP_REC_START;
          state_next = ST_REC;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_REC: begin
        if (sts.rec_end) begin
          cmd.op     = tcle_pkg::OP_REC_END;
          state_next = ST_FIN;
        end else begin
          cmd.op = tcle_pkg::OP_REC;
        end
      end
      ST_FWD: begin
        if (sts.cur_lt_end) begin
          cmd.op     = tcle_pkg::OP_FWD;
          state_next = ST_FWDCHK;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FWDCHK: begin
        // stop after the space that follows a word
        if (sts.space_rd) begin
          if (sts.cur_lt_end) cmd.op = tcle_pkg::OP_FWD;
          state_next = ST_FIN;
        end else begin
          state_next = ST_FWD;
        end
      end
      ST_RETYPE: begin
        cmd.rsel = tcle_pkg::RS_IDX;
        if (sts.rt_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.op = tcle_pkg::OP_RETYPE;
        end
      end
      ST_WORD0: begin
        cmd.rsel = tcle_pkg::RS_CURM1;
        if (!sts.cur_zero && sts.space_rd) cmd.op = tcle_pkg::OP_BACK;
        state_next = ST_WORD;
      end
      ST_WORD: begin
        if (sts.cur_zero) begin
          state_next = ST_FIN;
        end else begin
          cmd.op     = tcle_pkg::OP_WSTEP;
          state_next = ST_WCHK;
        end
      end
      ST_WCHK: begin
        if (sts.space_rd) begin
          cmd.op     = tcle_pkg::OP_FWD;
          state_next = ST_FIN;
        end else begin
          state_next = ST_WORD;
        end
      end
      ST_FIN: begin
        if (sts.res_zero) cmd.op = tcle_pkg::OP_STATUS;
        state_next = ST_RD;
      end
      ST_RD: begin
        cmd.op     = tcle_pkg::OP_RD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.op     = tcle_pkg::OP_NEXT;
          state_next = sts.res_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      to_rec <= 1'b0;
      werase <= 1'b0;
    end else begin
      state  <= state_next;
      to_rec <= to_rec_next;
      werase <= werase_next;
    end
  end

endmodule
